@@ rtl/ogg_phc_pkg.sv @@
// ----------------------------------------------------------------------------
// ogg_phc_pkg
// Types and constants for the Ogg page header checker: word structs for both
// channels, header layout offsets and the capture pattern.
// ----------------------------------------------------------------------------
package ogg_phc_pkg;

  localparam int unsigned PosWidth = 16;
  localparam int unsigned RecvWidth = PosWidth + 1;

  localparam logic [PosWidth-1:0] PosMax       = 16'hFFFF;
  localparam logic [PosWidth-1:0] PosVersion   = 16'd4;
  localparam logic [PosWidth-1:0] PosFlags     = 16'd5;
  localparam logic [PosWidth-1:0] PosSeqFirst  = 16'd18;
  localparam logic [PosWidth-1:0] PosSeqLast   = 16'd21;
  localparam logic [PosWidth-1:0] PosSegCount  = 16'd26;
  localparam logic [PosWidth-1:0] HdrBytes     = 16'd27;
  localparam logic [PosWidth-1:0] CaptureBytes = 16'd4;

  localparam logic [7:0] StreamVersion = 8'h00;
  localparam logic [7:0] FlagsMask     = 8'hF8;  // complement of the three legal flag bits

  // "OggS", byte 0 in the low lane
  localparam logic [3:0][7:0] CapturePattern = {8'h53, 8'h67, 8'h67, 8'h4F};

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_word_t;

  typedef struct packed {
    logic        is_page;
    logic [15:0] page_length;
    logic [31:0] page_number;
  } out_word_t;

endpackage

@@ rtl/ogg_page_header_checker.sv @@
// ----------------------------------------------------------------------------
// Throughput: one byte per cycle unless a last byte waits on a stalled result
// word; a byte register feeds the header logic and a result register holds the
// word until it is taken, so a last byte passes both before its result word.
// Reset: asynchronous, active low; resets all parse state and clears both valid flags.
// Parse state also returns to its reset values after every last byte.
// ----------------------------------------------------------------------------
// ogg_page_header_checker
// Checks the 27-byte Ogg page header of a byte stream, sums the segment table
// into the page length and reports one word per buffer on its last byte.
// ----------------------------------------------------------------------------
module ogg_page_header_checker (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  ogg_phc_pkg::in_word_t  in_data_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output ogg_phc_pkg::out_word_t out_data_o
);
  import ogg_phc_pkg::*;

  // byte register
  logic      byte_valid_q;
  in_word_t  byte_q;

  // parse state
  logic [PosWidth-1:0] pos_q, pos_d;
  logic                hdr_ok_q, hdr_ok_d;
  logic [7:0]          seg_count_q, seg_count_d;
  logic [15:0]         len_sum_q, len_sum_d;
  logic [31:0]         seq_num_q, seq_num_d;

  // result register
  logic      res_valid_q;
  out_word_t res_q;
  out_word_t res_d;

  logic out_free;
  logic byte_fire;
  logic in_fire;

  logic [PosWidth-1:0]  seq_off;
  logic [8:0]           table_end;
  logic [RecvWidth-1:0] received;
  logic                 page_ok;

  assign out_free   = !res_valid_q || !out_stall_i;
  // bytes that are not last never need the result register
  assign byte_fire  = byte_valid_q && (!byte_q.last_byte || out_free);
  assign in_stall_o = byte_valid_q && !byte_fire;
  assign in_fire    = in_valid_i && !in_stall_o;

  assign seq_off   = pos_q - PosSeqFirst;
  assign table_end = 9'(HdrBytes) + {1'b0, seg_count_q};

  always_comb begin
    hdr_ok_d    = hdr_ok_q;
    seg_count_d = seg_count_q;
    len_sum_d   = len_sum_q;
    seq_num_d   = seq_num_q;

    priority if (pos_q < CaptureBytes) begin
      if (byte_q.data_byte != CapturePattern[pos_q[1:0]]) hdr_ok_d = 1'b0;
    end else if (pos_q == PosVersion) begin
      if (byte_q.data_byte != StreamVersion) hdr_ok_d = 1'b0;
    end else if (pos_q == PosFlags) begin
      if ((byte_q.data_byte & FlagsMask) != 8'h00) hdr_ok_d = 1'b0;
    end else if (pos_q >= PosSeqFirst && pos_q <= PosSeqLast) begin
      unique case (seq_off[1:0])
        2'd0: seq_num_d[7:0]   = seq_num_q[7:0]   | byte_q.data_byte;
        2'd1: seq_num_d[15:8]  = seq_num_q[15:8]  | byte_q.data_byte;
        2'd2: seq_num_d[23:16] = seq_num_q[23:16] | byte_q.data_byte;
        default: seq_num_d[31:24] = seq_num_q[31:24] | byte_q.data_byte;
      endcase
    end else if (pos_q == PosSegCount) begin
      seg_count_d = byte_q.data_byte;
      len_sum_d   = HdrBytes + {8'h00, byte_q.data_byte};
    end else if (pos_q >= HdrBytes && pos_q < {7'h00, table_end}) begin
      len_sum_d = len_sum_q + {8'h00, byte_q.data_byte};
    end else begin
      // payload bytes and unchecked header fields
    end

    pos_d = (pos_q < PosMax) ? pos_q + 16'd1 : pos_q;
  end

  always_comb begin
    received = {1'b0, pos_q} + 17'd1;
    page_ok  = hdr_ok_d
            && received >= {1'b0, HdrBytes}
            && received >= 17'(HdrBytes) + 17'(seg_count_d)
            && received >= {1'b0, len_sum_d};
    res_d.is_page     = page_ok;
    res_d.page_length = page_ok ? len_sum_d : 16'h0000;
    res_d.page_number = page_ok ? seq_num_d : 32'h0000_0000;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_valid_q <= 1'b0;
    end else if (in_fire) begin
      byte_valid_q <= 1'b1;
    end else if (byte_fire) begin
      byte_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      byte_q <= in_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      hdr_ok_q    <= 1'b1;
      seg_count_q <= '0;
      len_sum_q   <= HdrBytes;
      seq_num_q   <= '0;
    end else if (byte_fire) begin
      if (byte_q.last_byte) begin
        // buffer done, start over
        pos_q       <= '0;
        hdr_ok_q    <= 1'b1;
        seg_count_q <= '0;
        len_sum_q   <= HdrBytes;
        seq_num_q   <= '0;
      end else begin
        pos_q       <= pos_d;
        hdr_ok_q    <= hdr_ok_d;
        seg_count_q <= seg_count_d;
        len_sum_q   <= len_sum_d;
        seq_num_q   <= seq_num_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (byte_fire && byte_q.last_byte) begin
      res_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (byte_fire && byte_q.last_byte) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = res_valid_q;
  assign out_data_o  = res_q;

endmodule

@@ sim/tb_ogg_page_header_checker.sv @@
// ----------------------------------------------------------------------------
// tb_ogg_page_header_checker
// Feeds byte buffers (well-formed pages, damaged headers, truncated pages,
// random noise and pages with trailing bytes) and compares every result word
// against a cycle-free model of the header parser.
// ----------------------------------------------------------------------------
module tb_ogg_page_header_checker;
  import ogg_phc_pkg::*;

  typedef logic [7:0] bytes_t[$];

  localparam int HoldCycles = 300;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_stall_o;
  in_word_t  in_data_i = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_word_t out_data_o;

  // parser state of the model
  logic [15:0] pos_q;
  logic        hdr_ok_q;
  logic [7:0]  seg_cnt_q;
  logic [15:0] len_sum_q;
  logic [31:0] seq_num_q;

  out_word_t expected_words[$];
  int        err_count = 0;
  int        send_idle_pct = 0;
  int        stall_pct = 0;
  logic      hold_pending = 1'b0;

  ogg_page_header_checker i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  always #2 clk_i = ~clk_i;

  initial begin
    #4_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic void clear_parse();
    pos_q     = '0;
    hdr_ok_q  = 1'b1;
    seg_cnt_q = '0;
    len_sum_q = HdrBytes;
    seq_num_q = '0;
  endfunction

  // advance the parser model by one accepted word
  function automatic void track_word(input logic [7:0] d, input logic l);
    logic [15:0] p;
    logic [16:0] received;
    logic        ok;
    out_word_t   w;
    p = pos_q;
    if (p < CaptureBytes) begin
      if (d != CapturePattern[p[1:0]]) hdr_ok_q = 1'b0;
    end else if (p == PosVersion) begin
      if (d != StreamVersion) hdr_ok_q = 1'b0;
    end else if (p == PosFlags) begin
      if ((d & FlagsMask) != 8'h00) hdr_ok_q = 1'b0;
    end else if (p >= PosSeqFirst && p <= PosSeqLast) begin
      seq_num_q = seq_num_q | (32'(d) << (8 * (p - PosSeqFirst)));
    end else if (p == PosSegCount) begin
      seg_cnt_q = d;
      len_sum_q = HdrBytes + 16'(d);
    end else if (p >= HdrBytes && p < HdrBytes + 16'(seg_cnt_q)) begin
      len_sum_q = len_sum_q + 16'(d);
    end
    if (pos_q != PosMax) pos_q = pos_q + 16'd1;
    if (l) begin
      received = 17'(p) + 17'd1;
      ok = hdr_ok_q && received >= 17'(HdrBytes)
           && received >= 17'(HdrBytes) + 17'(seg_cnt_q)
           && received >= 17'(len_sum_q);
      w.is_page     = ok;
      w.page_length = ok ? len_sum_q : 16'd0;
      w.page_number = ok ? seq_num_q : 32'd0;
      expected_words.push_back(w);
      clear_parse();
    end
  endfunction

  // result side: check each taken word, then pick the next stall value
  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) begin
        if (expected_words.size() == 0) begin
          $display("%0t: unexpected word, expected none, actual is_page %0b len %0d num %0d",
                   $time, out_data_o.is_page, out_data_o.page_length,
                   out_data_o.page_number);
          err_count++;
        end else begin
          out_word_t w;
          w = expected_words.pop_front();
          if (out_data_o.is_page !== w.is_page) begin
            $display("%0t: is_page expected %0b actual %0b", $time, w.is_page,
                     out_data_o.is_page);
            err_count++;
          end
          if (out_data_o.page_length !== w.page_length) begin
            $display("%0t: page_length expected %0d actual %0d", $time, w.page_length,
                     out_data_o.page_length);
            err_count++;
          end
          if (out_data_o.page_number !== w.page_number) begin
            $display("%0t: page_number expected %0h actual %0h", $time, w.page_number,
                     out_data_o.page_number);
            err_count++;
          end
        end
      end
      if (hold_pending) begin
        hold_left = HoldCycles;
        hold_pending = 1'b0;
      end
      if (hold_left > 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
      end else begin
        out_stall_i <= ($urandom_range(99, 0) < stall_pct);
      end
    end
  end

  task automatic send_word(input logic [7:0] d, input logic l);
    while ($urandom_range(99, 0) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= '{data_byte: d, last_byte: l};
    do @(posedge clk_i); while (in_stall_o);
    track_word(d, l);
  endtask

  task automatic send_buffer(input bytes_t data_bytes);
    for (int i = 0; i < data_bytes.size(); i++) begin
      send_word(data_bytes[i], logic'(i == data_bytes.size() - 1));
    end
  endtask

  task automatic build_page(output bytes_t pg, input logic [31:0] seq_no, input int nseg,
                            input int seg_lo, input int seg_hi);
    int         data_len;
    logic [7:0] seg_len;
    pg = {};
    for (int i = 0; i < 4; i++) pg.push_back(CapturePattern[i]);
    pg.push_back(StreamVersion);
    pg.push_back(8'($urandom_range(7, 0)));
    // granule position and stream serial
    for (int i = 0; i < 12; i++) pg.push_back(8'($urandom));
    for (int i = 0; i < 4; i++) pg.push_back(seq_no[8*i +: 8]);
    // crc field, never checked
    for (int i = 0; i < 4; i++) pg.push_back(8'($urandom));
    pg.push_back(8'(nseg));
    data_len = 0;
    for (int i = 0; i < nseg; i++) begin
      seg_len = 8'($urandom_range(seg_hi, seg_lo));
      pg.push_back(seg_len);
      data_len += seg_len;
    end
    for (int i = 0; i < data_len; i++) pg.push_back(8'($urandom));
  endtask

  task automatic test_header_cases();
    bytes_t pg;
    send_idle_pct = 20;
    stall_pct = 87;
    // smallest page, all-ones sequence number and all legal flags
    build_page(pg, 32'hFFFF_FFFF, 0, 0, 0);
    pg[5] = 8'h07;
    send_buffer(pg);
    // bytes after the page are ignored
    build_page(pg, 32'h0, 0, 0, 0);
    pg[5] = 8'h00;
    for (int i = 0; i < 3; i++) pg.push_back(8'hFF);
    send_buffer(pg);
    // table entries at both extremes
    build_page(pg, 32'h8040_2010, 3, 0, 0);
    pg[28] = 8'hFF;
    for (int i = 0; i < 255; i++) pg.push_back(8'($urandom));
    send_buffer(pg);
    // damage each checked header byte in turn
    for (int k = 0; k < 6; k++) begin
      build_page(pg, $urandom, 1, 0, 10);
      pg[k] = (k == 5) ? 8'h08 : ~pg[k];
      send_buffer(pg);
    end
    build_page(pg, $urandom, 0, 0, 0);
    pg[5] = 8'h80;
    send_buffer(pg);
    // one-word buffer
    pg = {8'hFF};
    send_buffer(pg);
    // header cut one short
    build_page(pg, $urandom, 0, 0, 0);
    void'(pg.pop_back());
    send_buffer(pg);
    // cut inside the segment table
    build_page(pg, $urandom, 4, 1, 5);
    while (pg.size() > 29) void'(pg.pop_back());
    send_buffer(pg);
    // one segment data word missing
    build_page(pg, $urandom, 2, 3, 9);
    void'(pg.pop_back());
    send_buffer(pg);
  endtask

  task automatic test_backpressure();
    bytes_t pg;
    send_idle_pct = 0;
    stall_pct = 0;
    hold_pending = 1'b1;
    // results pile up behind the held receiver until the input stalls
    for (int i = 0; i < 30; i++) begin
      if (i % 2 == 0) pg = {8'($urandom)};
      else build_page(pg, $urandom, 0, 0, 0);
      send_buffer(pg);
    end
  endtask

  task automatic test_random_buffers(input int send_pct, input int recv_pct,
                                     input int word_budget, input int min_buffers);
    bytes_t pg;
    int     sent;
    int     bufs;
    int     pick;
    int     n;
    send_idle_pct = send_pct;
    stall_pct = recv_pct;
    sent = 0;
    bufs = 0;
    while (sent < word_budget || bufs < min_buffers) begin
      pick = $urandom_range(99, 0);
      if (pick < 85) begin
        if (pick < 5) build_page(pg, $urandom, $urandom_range(3, 1), 128, 255);
        else build_page(pg, $urandom, $urandom_range(8, 0), 0, $urandom_range(40, 0));
        if (pick >= 55 && pick < 70) begin
          n = $urandom_range(pg.size() - 1, 1);
          while (pg.size() > n) void'(pg.pop_back());
        end else if (pick >= 70) begin
          n = $urandom_range(5, 0);
          pg[n] = pg[n] ^ 8'($urandom_range(255, 1));
        end
        sent += pg.size();
        if (pick >= 40 && pick < 55) begin
          repeat ($urandom_range(6, 1)) pg.push_back(8'($urandom));
        end
      end else begin
        pg = {};
        repeat ($urandom_range(40, 1)) pg.push_back(8'($urandom));
        sent += pg.size();
      end
      send_buffer(pg);
      bufs++;
    end
  endtask

  initial begin
    clear_parse();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_header_cases();
    test_backpressure();
    test_random_buffers(20, 87, 100, 2);
    test_random_buffers(87, 20, 100, 2);
    test_random_buffers(0, 0, 100, 2);
    in_valid_i <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (err_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
